>>> design/sdpcp_pkg.sv
// Shared types and constants for the serial decimal pulse command parser.
package sdpcp_pkg;

   // Line and parse sizing
   localparam int LINE_CHARS = 7;
   localparam int COUNT_W    = $clog2(LINE_CHARS + 1);
   localparam int ACC_W      = 24;
   localparam int PROD_W     = ACC_W + 4;
   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

   // Field and register widths
   localparam int BYTE_W   = 8;
   localparam int LIMIT_W  = 15;
   localparam int TICKS_W  = 16;
   localparam int CSR_IDX_W  = 1;

   // Character codes
   localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;
   localparam logic [BYTE_W-1:0] NUL_CODE     = 8'h00;
   localparam logic [BYTE_W-1:0] SPACE_CODE   = 8'h20;
   localparam logic [BYTE_W-1:0] TAB_CODE     = 8'h09;
   localparam logic [BYTE_W-1:0] CR_CODE      = 8'h0D;
   localparam logic [BYTE_W-1:0] PLUS_CODE    = 8'h2B;
   localparam logic [BYTE_W-1:0] MINUS_CODE   = 8'h2D;
   localparam logic [BYTE_W-1:0] ZERO_CODE    = 8'h30;
   localparam logic [BYTE_W-1:0] NINE_CODE    = 8'h39;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PULSE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PULSE = 1'b1;

   // Limit reset values
   localparam logic [LIMIT_W-1:0] MIN_PULSE_RESET = 15'd1000;
   localparam logic [LIMIT_W-1:0] MAX_PULSE_RESET = 15'd2000;

   typedef enum logic [1:0] {
      PHASE_SKIP   = 2'd0,
      PHASE_DIGITS = 2'd1,
      PHASE_DONE   = 2'd2
   } phase_type;

   typedef struct packed {
      logic                command_accepted;
      logic [TICKS_W-1:0]  pulse_ticks;
   } result_type;

endpackage

>>> design/serial_decimal_pulse_command_parser.sv
// Top level: input register, line parser, result register and limit registers.
//
//  channel  | ports                                      | direction
//  ---------+--------------------------------------------+----------
//  request  | req_valid, req_ready, req_rx_byte          | in
//  response | rsp_valid, rsp_ready, rsp_command_accepted,| out
//           | rsp_pulse_ticks                            |
//  csr      | csr_write_enable, csr_index, csr_wdata     | in
//
// One transaction per cycle sustained while the response is not stalled; a byte
// taken into the input register is parsed into the response register when it
// advances, and its response is offered from there. The parse state update is a
// single pass of short logic.
// Synchronous active-high reset clears parse state, held ticks and loads the
// default limits (1000 / 2000 us). A stalled response holds both registers;
// the request side keeps taking bytes as long as the input register drains.
module serial_decimal_pulse_command_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sdpcp_pkg::BYTE_W-1:0]        req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_command_accepted,
   output logic [sdpcp_pkg::TICKS_W-1:0]       rsp_pulse_ticks,
   input  logic                                csr_write_enable,
   input  logic [sdpcp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sdpcp_pkg::LIMIT_W-1:0]       csr_wdata
);

   logic                           in_valid_ff, in_valid_in;
   logic [sdpcp_pkg::BYTE_W-1:0]   in_byte_ff, in_byte_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   sdpcp_pkg::result_type          rsp_data_ff, rsp_data_in;
   logic [sdpcp_pkg::LIMIT_W-1:0]  min_ff, min_in;
   logic [sdpcp_pkg::LIMIT_W-1:0]  max_ff, max_in;

   logic                           advance;
   sdpcp_pkg::result_type          parse_result;

   // advance: the held byte moves into the response register this cycle
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   sdpcp_line_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .rx_byte      (in_byte_ff),
      .min_pulse_us (min_ff),
      .max_pulse_us (max_ff),
      .result       (parse_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = parse_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      min_in = min_ff;
      max_in = max_ff;
      if (csr_write_enable) begin
         case (csr_index)
            sdpcp_pkg::CSR_MIN_PULSE: min_in = csr_wdata;
            sdpcp_pkg::CSR_MAX_PULSE: max_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_ff       <= sdpcp_pkg::MIN_PULSE_RESET;
         max_ff       <= sdpcp_pkg::MAX_PULSE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_command_accepted = rsp_data_ff.command_accepted;
   assign rsp_pulse_ticks      = rsp_data_ff.pulse_ticks;

endmodule

>>> design/sdpcp_line_parser.sv
// Per-byte line parser: running parse state, range check and held timer value.
module sdpcp_line_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [sdpcp_pkg::BYTE_W-1:0]      rx_byte,
   input  logic [sdpcp_pkg::LIMIT_W-1:0]     min_pulse_us,
   input  logic [sdpcp_pkg::LIMIT_W-1:0]     max_pulse_us,
   output sdpcp_pkg::result_type             result
);

   logic [sdpcp_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                           ovf_ff, ovf_in;
   sdpcp_pkg::phase_type           phase_ff, phase_in;
   logic                           neg_ff, neg_in;
   logic [sdpcp_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic [sdpcp_pkg::TICKS_W-1:0]  ticks_ff, ticks_in;

   logic                           is_digit;
   logic [sdpcp_pkg::PROD_W-1:0]   prod;
   logic [sdpcp_pkg::ACC_W-1:0]    acc_sat;
   logic                           in_range;

   always_comb begin
      is_digit = (rx_byte >= sdpcp_pkg::ZERO_CODE) && (rx_byte <= sdpcp_pkg::NINE_CODE);
      // acc*10 + digit as acc*8 + acc*2 + digit
      prod = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
             + {{(sdpcp_pkg::PROD_W-4){1'b0}}, rx_byte[3:0]};
      acc_sat = (prod > {4'b0000, sdpcp_pkg::ACC_MAX}) ? sdpcp_pkg::ACC_MAX
                                                       : prod[sdpcp_pkg::ACC_W-1:0];
      if (neg_ff) begin
         in_range = (acc_ff == '0) && (min_pulse_us == '0) && (max_pulse_us >= min_pulse_us);
      end else begin
         in_range = (acc_ff >= {{(sdpcp_pkg::ACC_W-sdpcp_pkg::LIMIT_W){1'b0}}, min_pulse_us})
                 && (acc_ff <= {{(sdpcp_pkg::ACC_W-sdpcp_pkg::LIMIT_W){1'b0}}, max_pulse_us});
      end
   end

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      phase_in = phase_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      ticks_in = ticks_ff;
      result.command_accepted = 1'b0;
      if (advance) begin
         if (rx_byte == sdpcp_pkg::NEWLINE_CODE) begin
            if (!ovf_ff && in_range) begin
               result.command_accepted = 1'b1;
               ticks_in = {acc_ff[sdpcp_pkg::TICKS_W-2:0], 1'b0};
            end
            ovf_in   = 1'b0;
            count_in = '0;
            phase_in = sdpcp_pkg::PHASE_SKIP;
            neg_in   = 1'b0;
            acc_in   = '0;
         end else if (count_ff >= sdpcp_pkg::COUNT_W'(sdpcp_pkg::LINE_CHARS)) begin
            // line too long: drop byte, mark overflow, start counting again
            ovf_in   = 1'b1;
            count_in = '0;
            phase_in = sdpcp_pkg::PHASE_SKIP;
            neg_in   = 1'b0;
            acc_in   = '0;
         end else begin
            count_in = count_ff + sdpcp_pkg::COUNT_W'(1);
            if (rx_byte == sdpcp_pkg::NUL_CODE) begin
               phase_in = sdpcp_pkg::PHASE_DONE;
            end else if (phase_ff != sdpcp_pkg::PHASE_DONE) begin
               if (is_digit) begin
                  acc_in   = acc_sat;
                  phase_in = sdpcp_pkg::PHASE_DIGITS;
               end else if (phase_ff == sdpcp_pkg::PHASE_SKIP &&
                            (rx_byte inside {sdpcp_pkg::SPACE_CODE,
                                             [sdpcp_pkg::TAB_CODE:sdpcp_pkg::CR_CODE]})) begin
                  phase_in = sdpcp_pkg::PHASE_SKIP;
               end else if (phase_ff == sdpcp_pkg::PHASE_SKIP &&
                            (rx_byte inside {sdpcp_pkg::PLUS_CODE, sdpcp_pkg::MINUS_CODE})) begin
                  neg_in   = (rx_byte == sdpcp_pkg::MINUS_CODE);
                  phase_in = sdpcp_pkg::PHASE_DIGITS;
               end else begin
                  phase_in = sdpcp_pkg::PHASE_DONE;
               end
            end
         end
      end
      result.pulse_ticks = ticks_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         phase_ff <= sdpcp_pkg::PHASE_SKIP;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
         ticks_ff <= '0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
         ticks_ff <= ticks_in;
      end
   end

endmodule
